/* rtl/swmma_pkg.sv */
// Shared widths, register indexes and reset values for the sliding window statistics unit.
`timescale 1ns / 1ps

package swmma_pkg;

   // window length; a power of two, so the floor mean is an arithmetic shift
   localparam int WINDOW   = 64;

   localparam int TIME_W   = 32;
   localparam int SAMPLE_W = 16;
   localparam int CFG_W    = 16;
   localparam int OUT_W    = 24;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_INTERVAL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE    = 2'd1;

   localparam logic [CFG_W-1:0] INTERVAL_RESET = 16'd100;
   localparam logic [CFG_W-1:0] SCALE_RESET    = 16'd256;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

endpackage

/* rtl/swmma_div.sv */
// Floor division of the window sum by the window length, by an arithmetic shift.
`timescale 1ns / 1ps

module swmma_div
   import swmma_pkg::*;
#(
   parameter int SUM_W = 22
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic signed [SUM_W-1:0]    dividend,
   output logic                       done,
   output logic signed [SAMPLE_W-1:0] quotient
);

   localparam int SHIFT = $clog2(WINDOW);

   logic                       done_ff, done_in;
   logic signed [SAMPLE_W-1:0] quo_ff, quo_in;

   always_comb begin
      done_in = start;
      quo_in  = quo_ff;
      if (start) begin
         // dropping the low bits of a two's complement sum floors toward minus infinity
         quo_in = dividend[SHIFT +: SAMPLE_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

/* rtl/sliding_window_min_max_avg_unit.sv */
// Sliding window minimum, maximum and mean of a timed sample stream, scaled by a Q8.8 factor.
`timescale 1ns / 1ps

// A request carries a millisecond timestamp and a signed 16-bit sample. When
// now_ms minus the time of the last taken sample (mod 2^32) reaches interval_ms,
// the sample replaces the oldest of WINDOW stored samples and one response
// returns min, max and floor mean of the window, each times scale_q8 >> 8;
// otherwise no response is made. WINDOW is a package constant (a power of two).
// After reset the window memory is zeroed slot by slot with req_tready low.
// Each item is handled alone: a skipped item is taken and checked; a taken
// item is also stored, then the single-port window memory is walked, the
// shifted mean is formed, the shared multiplier scales min, max and mean in
// turn and the response register is loaded. A response still waiting in that
// register stalls only the final load. CSR writes are taken at any time but
// belong in idle.
module sliding_window_min_max_avg_unit
   import swmma_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // [31:0] now_ms, [47:32] sample
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [47:0]          req_tdata,
   // [23:0] min_scaled, [47:24] max_scaled, [71:48] avg_scaled
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [71:0]          rsp_tdata,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_data
);

   localparam int AW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CW    = $clog2(WINDOW + 1);
   localparam int SUM_W = SAMPLE_W + AW;
   localparam int PW    = 2 * SAMPLE_W + 1;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_CHECK, ST_WRITE, ST_SCAN, ST_DIV, ST_MUL, ST_DONE
   } state_type;

   state_type state_ff, state_in;

   logic [CFG_W-1:0]          interval_ff, interval_in;
   logic [CFG_W-1:0]          scale_ff, scale_in;
   logic [TIME_W-1:0]         last_time_ff, last_time_in;
   logic [TIME_W-1:0]         now_ff, now_in;
   logic signed [SAMPLE_W-1:0] sample_ff, sample_in;
   logic [AW-1:0]             clr_cnt_ff, clr_cnt_in;
   logic [AW-1:0]             wr_ptr_ff, wr_ptr_in;
   logic [CW-1:0]             scan_cnt_ff, scan_cnt_in;
   logic                      rd_vld_ff, rd_vld_in;
   logic signed [SAMPLE_W-1:0] lo_ff, lo_in, hi_ff, hi_in, avg_ff, avg_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic [1:0]                mul_cnt_ff, mul_cnt_in;
   logic signed [PW-1:0]      prod_ff, prod_in;
   logic [OUT_W-1:0]          min_res_ff, min_res_in, max_res_ff, max_res_in;
   logic [OUT_W-1:0]          avg_res_ff, avg_res_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [71:0]               rsp_data_ff, rsp_data_in;

   logic [TIME_W-1:0]          elapsed;
   logic signed [SAMPLE_W-1:0] mul_op;
   logic                       div_start;
   logic                       div_done;
   logic signed [SAMPLE_W-1:0] div_q;

   // window memory
   logic [SAMPLE_W-1:0]        mem [WINDOW];
   logic                       mem_we;
   logic [AW-1:0]              mem_wa;
   logic [SAMPLE_W-1:0]        mem_wd;
   logic [AW-1:0]              mem_ra;
   logic signed [SAMPLE_W-1:0] rd_data_ff;

   assign mem_we = (state_ff == ST_CLEAR) || (state_ff == ST_WRITE);
   assign mem_wa = (state_ff == ST_CLEAR) ? clr_cnt_ff : wr_ptr_ff;
   assign mem_wd = (state_ff == ST_CLEAR) ? '0 : sample_ff;
   assign mem_ra = scan_cnt_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[mem_ra];
   end

   assign elapsed   = now_ff - last_time_ff;
   assign div_start = (state_ff == ST_SCAN) && (scan_cnt_ff == CW'(WINDOW)) && !rd_vld_ff;

   always_comb begin
      unique case (mul_cnt_ff)
         2'd0:    mul_op = lo_ff;
         2'd1:    mul_op = hi_ff;
         default: mul_op = avg_ff;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      interval_in  = interval_ff;
      scale_in     = scale_ff;
      last_time_in = last_time_ff;
      now_in       = now_ff;
      sample_in    = sample_ff;
      clr_cnt_in   = clr_cnt_ff;
      wr_ptr_in    = wr_ptr_ff;
      scan_cnt_in  = scan_cnt_ff;
      rd_vld_in    = 1'b0;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      sum_in       = sum_ff;
      avg_in       = avg_ff;
      mul_cnt_in   = mul_cnt_ff;
      prod_in      = prod_ff;
      min_res_in   = min_res_ff;
      max_res_in   = max_res_ff;
      avg_res_in   = avg_res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid) begin
         unique case (csr_index)
            CSR_INTERVAL: interval_in = csr_data;
            CSR_SCALE:    scale_in    = csr_data;
            default:      ;
         endcase
      end

      unique case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == AW'(WINDOW - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               now_in    = req_tdata[31:0];
               sample_in = req_tdata[47:32];
               state_in  = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (elapsed >= TIME_W'(interval_ff)) begin
               last_time_in = now_ff;
               state_in     = ST_WRITE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_WRITE: begin
            // sample overwrites the oldest slot; the scan order does not matter
            wr_ptr_in   = (wr_ptr_ff == AW'(WINDOW - 1)) ? '0 : wr_ptr_ff + 1'b1;
            scan_cnt_in = '0;
            lo_in       = SAMPLE_MAX;
            hi_in       = SAMPLE_MIN;
            sum_in      = '0;
            state_in    = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_cnt_ff != CW'(WINDOW)) begin
               rd_vld_in   = 1'b1;
               scan_cnt_in = scan_cnt_ff + 1'b1;
            end
            if (rd_vld_ff) begin
               if (rd_data_ff < lo_ff) lo_in = rd_data_ff;
               if (rd_data_ff > hi_ff) hi_in = rd_data_ff;
               sum_in = sum_ff + SUM_W'(rd_data_ff);
            end
            if (div_start) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               avg_in     = div_q;
               mul_cnt_in = '0;
               state_in   = ST_MUL;
            end
         end
         ST_MUL: begin
            // one multiplier: product of step k is sliced in step k+1
            prod_in    = PW'(mul_op) * PW'($signed({1'b0, scale_ff}));
            mul_cnt_in = mul_cnt_ff + 1'b1;
            unique case (mul_cnt_ff)
               2'd0:    ;
               2'd1:    min_res_in = prod_ff[OUT_W+7:8];
               2'd2:    max_res_in = prod_ff[OUT_W+7:8];
               default: begin
                  avg_res_in = prod_ff[OUT_W+7:8];
                  state_in   = ST_DONE;
               end
            endcase
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {avg_res_ff, max_res_ff, min_res_ff};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         interval_ff  <= INTERVAL_RESET;
         scale_ff     <= SCALE_RESET;
         last_time_ff <= '0;
         clr_cnt_ff   <= '0;
         wr_ptr_ff    <= '0;
         scan_cnt_ff  <= '0;
         rd_vld_ff    <= 1'b0;
         mul_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         interval_ff  <= interval_in;
         scale_ff     <= scale_in;
         last_time_ff <= last_time_in;
         clr_cnt_ff   <= clr_cnt_in;
         wr_ptr_ff    <= wr_ptr_in;
         scan_cnt_ff  <= scan_cnt_in;
         rd_vld_ff    <= rd_vld_in;
         mul_cnt_ff   <= mul_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      now_ff      <= now_in;
      sample_ff   <= sample_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      sum_ff      <= sum_in;
      avg_ff      <= avg_in;
      prod_ff     <= prod_in;
      min_res_ff  <= min_res_in;
      max_res_ff  <= max_res_in;
      avg_res_ff  <= avg_res_in;
      rsp_data_ff <= rsp_data_in;
   end

   swmma_div #(
      .SUM_W (SUM_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_in),
      .done     (div_done),
      .quotient (div_q)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

`ifndef SYNTH
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider finished outside divide phase");

   a_min_le_max: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (lo_ff <= hi_ff))
      else $error("window minimum above maximum");

   a_avg_in_range: assert property (@(posedge clock) disable iff (reset)
      div_done |-> ((div_q >= lo_ff) && (div_q <= hi_ff)))
      else $error("mean outside window range");

   a_wr_ptr_range: assert property (@(posedge clock) disable iff (reset)
      wr_ptr_ff <= AW'(WINDOW - 1))
      else $error("write pointer beyond window");

   a_clear_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_tready)
      else $error("item taken during memory clear");
`endif

endmodule

/* bench/window_stats_checker.sv */
// Checker that predicts and compares the windowed min, max and mean results.
`timescale 1ns / 1ps

module window_stats_checker
   import swmma_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tready,
   input  logic [47:0]          req_tdata,   // [31:0] now_ms, [47:32] sample
   input  logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic [71:0]          rsp_tdata,   // [23:0] min, [47:24] max, [71:48] avg
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_data,
   input  logic                 run_done,
   output int                   fail_count,
   output int                   pending,
   output int                   results_seen
);

   typedef struct packed {
      logic [OUT_W-1:0] min_scaled;
      logic [OUT_W-1:0] max_scaled;
      logic [OUT_W-1:0] avg_scaled;
   } window_stats_type;

   logic signed [SAMPLE_W-1:0] window_q [WINDOW];
   logic [TIME_W-1:0]          last_taken_ms;
   logic [CFG_W-1:0]           interval_ms;
   logic [CFG_W-1:0]           scale_q8;
   window_stats_type           stats_due_q [$];
   bit                         leftovers_reported = 1'b0;

   initial begin
      fail_count   = 0;
      pending      = 0;
      results_seen = 0;
   end

   task automatic report_mismatch(input string what);
      if (fail_count < 20) begin
         $display("[%0t] window stats mismatch: %s", $time, what);
      end
      fail_count++;
   endtask

   // value * scale, floored by the arithmetic shift, kept to the result width
   function automatic logic [OUT_W-1:0] apply_scale(input longint value);
      longint product;
      product = value * longint'(scale_q8);
      product = product >>> 8;
      return product[OUT_W-1:0];
   endfunction

   // Window update and expected statistics for one accepted item.
   task automatic take_sample(input logic [TIME_W-1:0] now_ms,
                              input logic signed [SAMPLE_W-1:0] smp);
      logic [TIME_W-1:0] elapsed;
      longint            lo;
      longint            hi;
      longint            total;
      longint            mean;
      window_stats_type  due;
      elapsed = now_ms - last_taken_ms;
      if (elapsed < interval_ms) return;
      for (int i = 0; i < WINDOW - 1; i++) window_q[i] = window_q[i + 1];
      window_q[WINDOW - 1] = smp;
      last_taken_ms = now_ms;
      lo    = 32767;
      hi    = -32768;
      total = 0;
      foreach (window_q[i]) begin
         if (window_q[i] > hi) hi = window_q[i];
         if (window_q[i] < lo) lo = window_q[i];
         total += window_q[i];
      end
      mean = (total >= 0) ? total / WINDOW : -((-total + WINDOW - 1) / WINDOW);
      due.min_scaled = apply_scale(lo);
      due.max_scaled = apply_scale(hi);
      due.avg_scaled = apply_scale(mean);
      stats_due_q.push_back(due);
   endtask

   always @(posedge clock) begin
      window_stats_type due;
      if (reset) begin
         foreach (window_q[i]) window_q[i] = '0;
         last_taken_ms = '0;
         interval_ms   = INTERVAL_RESET;
         scale_q8      = SCALE_RESET;
         stats_due_q.delete();
      end else begin
         // results leave before a new item can be taken in the same cycle
         if (rsp_tvalid && rsp_tready) begin
            if (stats_due_q.size() == 0) begin
               report_mismatch($sformatf("result %h with none expected", rsp_tdata));
            end else begin
               due = stats_due_q.pop_front();
               results_seen++;
               if (rsp_tdata[23:0] !== due.min_scaled)
                  report_mismatch($sformatf("min %h, expected %h",
                                            rsp_tdata[23:0], due.min_scaled));
               if (rsp_tdata[47:24] !== due.max_scaled)
                  report_mismatch($sformatf("max %h, expected %h",
                                            rsp_tdata[47:24], due.max_scaled));
               if (rsp_tdata[71:48] !== due.avg_scaled)
                  report_mismatch($sformatf("avg %h, expected %h",
                                            rsp_tdata[71:48], due.avg_scaled));
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_INTERVAL: interval_ms = csr_data;
               CSR_SCALE:    scale_q8    = csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) take_sample(req_tdata[31:0], req_tdata[47:32]);
         if (run_done && !leftovers_reported) begin
            foreach (stats_due_q[i])
               report_mismatch($sformatf("result never came: min %h max %h avg %h",
                                         stats_due_q[i].min_scaled,
                                         stats_due_q[i].max_scaled,
                                         stats_due_q[i].avg_scaled));
            leftovers_reported = 1'b1;
         end
      end
      pending = stats_due_q.size();
   end

endmodule

/* bench/tb_sliding_window_min_max_avg_unit.sv */
// Testbench top: stimulus, receiver stalls and verdict for the sliding window statistics unit.
`timescale 1ns / 1ps

module tb_sliding_window_min_max_avg_unit
   import swmma_pkg::*;
();

   localparam int SETTLE_CYCLES = WINDOW + 40;
   localparam int CYCLE_LIMIT   = 1_500_000;

   typedef enum int {SMP_FULL, SMP_NEGATIVE, SMP_EXTREME, SMP_MIXED} sample_mix_type;
   typedef enum int {RX_OPEN, RX_COIN, RX_PERIODIC, RX_LONG_STALL} rx_pattern_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [47:0]          req_tdata;    // [31:0] now_ms, [47:32] sample
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [71:0]          rsp_tdata;    // [23:0] min, [47:24] max, [71:48] avg
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_data;
   logic                 run_done;

   int                   fail_count;
   int                   pending;
   int                   results_seen;
   int                   items_sent     = 0;
   int                   settings_count = 0;
   int unsigned          cycle_count    = 0;
   logic [TIME_W-1:0]    stamp_ms;
   logic [CFG_W-1:0]     interval_now;

   rx_pattern_type       rx_pattern = RX_OPEN;
   int unsigned          rx_cycle   = 0;
   int                   rx_hold    = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   sliding_window_min_max_avg_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   window_stats_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .run_done     (run_done),
      .fail_count   (fail_count),
      .pending      (pending),
      .results_seen (results_seen)
   );

   // Receiver stalls: a new pattern is drawn whenever the low byte of rx_cycle is zero.
   always @(negedge clock) begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle[7:0] == 8'd0) rx_pattern <= rx_pattern_type'($urandom_range(0, 3));
      case (rx_pattern)
         RX_OPEN:     rsp_tready <= 1'b1;
         RX_COIN:     rsp_tready <= 1'($urandom_range(0, 1));
         RX_PERIODIC: rsp_tready <= (rx_cycle % 3 == 0);
         default: begin
            if (rx_hold == 0) begin
               rx_hold    <= $urandom_range(1, 24);
               rsp_tready <= ~rsp_tready;
            end else begin
               rx_hold <= rx_hold - 1;
            end
         end
      endcase
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d results outstanding",
                  cycle_count, pending);
         $display("tb_sliding_window_min_max_avg_unit: FAIL");
         $finish;
      end
   end

   // Called and returns at a falling edge; leaves req_tvalid high.
   task automatic send_item(input logic [TIME_W-1:0] now_ms,
                            input logic [SAMPLE_W-1:0] smp);
      req_tvalid <= 1'b1;
      req_tdata  <= {smp, now_ms};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   // Registers change only once every result is out and the block has gone quiet.
   task automatic program_regs(input logic [CFG_W-1:0] interval, input logic [CFG_W-1:0] scale);
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      write_csr(CSR_INTERVAL, interval);
      write_csr(CSR_SCALE, scale);
      csr_valid    <= 1'b0;
      interval_now  = interval;
      settings_count++;
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_sample(input sample_mix_type mix);
      sample_mix_type m;
      m = (mix == SMP_MIXED) ? sample_mix_type'($urandom_range(0, 2)) : mix;
      case (m)
         SMP_NEGATIVE: return {1'b1, 15'($urandom)};
         SMP_EXTREME: begin
            case ($urandom_range(0, 4))
               0:       return SAMPLE_MAX;
               1:       return SAMPLE_MIN;
               2:       return '0;
               3:       return '1;
               default: return 16'd1;
            endcase
         end
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic run_phase(input logic [CFG_W-1:0] interval, input logic [CFG_W-1:0] scale,
                            input int n_items, input sample_mix_type mix, input bit gappy);
      int sent;
      int burst;
      int gap;
      int roll;
      program_regs(interval, scale);
      sent = 0;
      while (sent < n_items) begin
         burst = $urandom_range(1, 24);
         for (int k = 0; k < burst && sent < n_items; k++) begin
            // mostly on time, some too early, some repeated, some jumps anywhere
            roll = $urandom_range(0, 99);
            if (roll < 70)
               stamp_ms = stamp_ms + interval_now + $urandom_range(0, 3);
            else if (roll < 85)
               stamp_ms = stamp_ms + ((interval_now == 0) ? 0 :
                                      $urandom_range(0, interval_now - 1));
            else if (roll >= 92)
               stamp_ms = $urandom();
            send_item(stamp_ms, pick_sample(mix));
            sent++;
         end
         gap = gappy ? $urandom_range(0, 10) : 0;
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_tvalid <= 1'b0;
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_index  = CSR_INTERVAL;
      csr_data   = '0;
      run_done   = 1'b0;
      interval_now = INTERVAL_RESET;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset register values: 100 ms interval, unity scale
      send_item(32'd0, 16'd1);                 // no time elapsed: skipped
      send_item(32'd99, SAMPLE_MAX);           // one short of the interval
      send_item(32'd100, SAMPLE_MAX);          // exactly the interval
      send_item(32'd150, SAMPLE_MIN);
      send_item(32'd200, SAMPLE_MIN);
      send_item(32'd210, 16'hFFFF);
      send_item(32'd300, 16'hFFFF);
      send_item(32'd50, 16'h0001);             // timestamp stepped back
      send_item(32'hFFFF_FFF0, 16'h5555);
      send_item(32'h0000_0053, 16'h1234);      // 99 ms across the wrap
      send_item(32'h0000_0054, 16'hAAAA);      // 100 ms across the wrap
      send_item(32'hFFFF_FFFF, 16'h8001);
      send_item(32'h7FFF_FFFF, 16'h7FFE);
      req_tvalid <= 1'b0;

      // zero interval takes every item; full-range scale
      program_regs(16'd0, 16'hFFFF);
      send_item(32'h7FFF_FFFF, SAMPLE_MAX);
      send_item(32'h7FFF_FFFF, SAMPLE_MAX);
      send_item(32'h7FFF_FFFF, SAMPLE_MIN);
      send_item(32'h7FFF_FFFF, 16'h0000);
      req_tvalid <= 1'b0;
      program_regs(16'd0, 16'd0);
      send_item(32'h7FFF_FFFF, SAMPLE_MIN);
      send_item(32'h7FFF_FFFF, SAMPLE_MAX);
      req_tvalid <= 1'b0;
      stamp_ms = 32'h7FFF_FFFF;

      run_phase(16'd0,     16'd0,     100, SMP_FULL,     1'b1);
      run_phase(16'd0,     16'd256,   200, SMP_NEGATIVE, 1'b0);
      run_phase(16'd100,   16'd256,   300, SMP_FULL,     1'b1);
      run_phase(16'hFFFF,  16'hFFFF,  250, SMP_EXTREME,  1'b1);
      run_phase(16'd1,     16'd128,   250, SMP_MIXED,    1'b0);
      repeat (4) begin
         run_phase(16'($urandom_range(0, 300)), 16'($urandom), 200, SMP_MIXED, 1'b1);
      end

      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      run_done <= 1'b1;
      repeat (2) @(negedge clock);

      $display("Sent %0d items over %0d register settings; %0d results checked.",
               items_sent, settings_count, results_seen);
      $display("Covered wrapped and backward timestamps, zero and full scale, negative windows.");
      if (fail_count == 0) begin
         $display("tb_sliding_window_min_max_avg_unit: PASS");
      end else begin
         $display("tb_sliding_window_min_max_avg_unit: FAIL");
      end
      $finish;
   end

endmodule
